### rtl/core/trie_pkg.sv
// Shared types, codes and defaults of the trie insert and lookup unit.
`timescale 1ns / 1ps
`default_nettype none

package trie_pkg;

   // Default sizes of the node pool and the alphabet
   localparam int DEF_MAX_NODES  = 1024;
   localparam int DEF_ALPHA_SIZE = 26;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int CODE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int WORDS_W  = 16;
   localparam int NODES_W  = 11;

   // Configuration port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-3:0] REG_CHAR_BASE = 1'd0;
   localparam logic [CODE_W-1:0]  CHAR_BASE_RST = 8'd97;

   // Commands
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADCHAR = 2'd2;

   localparam logic [WORDS_W-1:0] WORDS_MAX = 16'hFFFF;

   typedef struct packed {
      logic                found;
      logic [STATUS_W-1:0] status;
      logic [WORDS_W-1:0]  words_stored;
      logic [NODES_W-1:0]  nodes_used;
      logic                done_res;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/trie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module trie_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/trie_csr.sv
// Configuration register block: alphabet base character.
`timescale 1ns / 1ps
`default_nettype none

module trie_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [trie_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [trie_pkg::PDATA_W-1:0]  pwdata,
   output logic      [trie_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready,
   output logic      [trie_pkg::CODE_W-1:0]   char_base
);
   import trie_pkg::*;

   logic [CODE_W-1:0]    char_base_ff;
   logic [CODE_W-1:0]    char_base_in;
   logic [PADDR_W-3:0]   reg_sel;
   logic                 wr_go;

   assign reg_sel = paddr[PADDR_W-1:2];
   assign wr_go   = psel && penable && pwrite;

   always_comb begin
      char_base_in = char_base_ff;
      if (wr_go && (reg_sel == REG_CHAR_BASE)) begin
         char_base_in = pwdata[CODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_base_ff <= CHAR_BASE_RST;
      end else begin
         char_base_ff <= char_base_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel == REG_CHAR_BASE) begin
         prdata = PDATA_W'(char_base_ff);
      end
   end

   assign pready    = 1'b1;
   assign char_base = char_base_ff;

endmodule

`default_nettype wire

### rtl/core/trie_ctrl.sv
// Trie walk engine: link lookup, node allocation, marks, counters, result register.
`timescale 1ns / 1ps
`default_nettype none

module trie_ctrl #(
   parameter int  MAX_NODES  = trie_pkg::DEF_MAX_NODES,
   parameter int  ALPHA_SIZE = trie_pkg::DEF_ALPHA_SIZE,
   localparam int NODE_W     = $clog2(MAX_NODES),
   localparam int LINK_DEPTH = MAX_NODES * ALPHA_SIZE,
   localparam int LINK_AW    = $clog2(LINK_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [trie_pkg::CODE_W-1:0] char_base,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [trie_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [trie_pkg::CODE_W-1:0] req_char_code,
   input  wire logic                        req_no_char,
   input  wire logic                        req_last_char,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output trie_pkg::rsp_type                rsp,
   output logic                             link_we,
   output logic      [LINK_AW-1:0]          link_waddr,
   output logic      [NODE_W-1:0]           link_wdata,
   output logic                             link_re,
   output logic      [LINK_AW-1:0]          link_raddr,
   input  wire logic [NODE_W-1:0]           link_rdata,
   output logic                             mark_we,
   output logic      [NODE_W-1:0]           mark_waddr,
   output logic                             mark_wdata,
   output logic                             mark_re,
   output logic      [NODE_W-1:0]           mark_raddr,
   input  wire logic                        mark_rdata
);
   import trie_pkg::*;

   localparam int NTW = $clog2(MAX_NODES + 1);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_MARK  = 2'd3;

   logic [1:0]          state_ff,      state_in;
   logic [LINK_AW-1:0]  clr_cnt_ff,    clr_cnt_in;
   logic [NODE_W-1:0]   cursor_ff,     cursor_in;
   logic [NTW-1:0]      node_total_ff, node_total_in;
   logic [WORDS_W-1:0]  word_total_ff, word_total_in;
   logic                failed_ff,     failed_in;
   logic                rsp_valid_ff,  rsp_valid_in;
   rsp_type             rsp_ff,        rsp_in;
   logic [CMD_W-1:0]    cmd_ff,        cmd_in;
   logic [CODE_W-1:0]   idx_ff,        idx_in;
   logic                no_char_ff,    no_char_in;
   logic                last_ff,       last_in;
   logic [LINK_AW-1:0]  slot_ff,       slot_in;

   logic                accept;
   logic                out_free;
   logic                look_go;
   logic                mark_go;
   logic [CODE_W-1:0]   req_idx;
   logic                req_walk;
   logic                act;
   logic                bad;
   logic                miss;
   logic                full;
   logic                alloc;
   logic                fail_now;
   logic                fail_new;
   logic [NODE_W-1:0]   nxt;
   logic [NODE_W-1:0]   step_cursor;
   logic                need_mark;
   logic                mark_set;
   logic [STATUS_W-1:0] look_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign look_go   = (state_ff == ST_LOOK) && out_free;
   assign mark_go   = (state_ff == ST_MARK) && out_free;

   // Alphabet index wraps modulo 256; read the link only for a real step
   assign req_idx  = req_char_code - char_base;
   assign req_walk = (req_cmd != CMD_NONE) && !req_no_char && !failed_ff &&
                     ({1'b0, req_idx} < (CODE_W + 1)'(ALPHA_SIZE));
   assign slot_in  = LINK_AW'(cursor_ff) * LINK_AW'(ALPHA_SIZE) + LINK_AW'(req_idx);

   // Decisions on the link word read for the held request
   assign act      = (cmd_ff != CMD_NONE) && !no_char_ff && !failed_ff;
   assign bad      = ({1'b0, idx_ff} >= (CODE_W + 1)'(ALPHA_SIZE));
   assign miss     = (link_rdata == '0);
   assign full     = (node_total_ff == NTW'(MAX_NODES));
   assign alloc    = act && !bad && miss && (cmd_ff == CMD_INSERT) && !full;
   assign fail_now = act && (bad || (miss && ((cmd_ff != CMD_INSERT) || full)));
   assign fail_new = failed_ff || fail_now;
   assign nxt      = alloc ? node_total_ff[NODE_W-1:0] : link_rdata;
   assign step_cursor = (act && !fail_now) ? nxt : cursor_ff;
   assign need_mark   = last_ff && (cmd_ff == CMD_EXACT) && !fail_new;
   assign mark_set    = last_ff && (cmd_ff == CMD_INSERT) && !fail_new;

   always_comb begin
      look_status = STAT_OK;
      if (act && bad) begin
         look_status = STAT_BADCHAR;
      end else if (act && miss && (cmd_ff == CMD_INSERT) && full) begin
         look_status = STAT_FULL;
      end
   end

   // Memory ports: clearing sweep, link lookup, allocation, marks
   always_comb begin
      link_re    = accept && req_walk;
      link_raddr = slot_in;
      link_we    = 1'b0;
      link_waddr = slot_ff;
      link_wdata = node_total_ff[NODE_W-1:0];
      mark_we    = 1'b0;
      mark_waddr = step_cursor;
      mark_wdata = 1'b1;
      mark_re    = look_go && need_mark;
      mark_raddr = step_cursor;
      if (state_ff == ST_CLEAR) begin
         link_we    = 1'b1;
         link_waddr = clr_cnt_ff;
         link_wdata = '0;
         mark_we    = (clr_cnt_ff < LINK_AW'(MAX_NODES));
         mark_waddr = clr_cnt_ff[NODE_W-1:0];
         mark_wdata = 1'b0;
      end else if (look_go) begin
         link_we = alloc;
         mark_we = mark_set;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      cursor_in     = cursor_ff;
      node_total_in = node_total_ff;
      word_total_in = word_total_ff;
      failed_in     = failed_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      no_char_in    = no_char_ff;
      last_in       = last_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LINK_AW'(LINK_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               idx_in     = req_idx;
               no_char_in = req_no_char;
               last_in    = req_last_char;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_go) begin
               if (alloc) begin
                  node_total_in = node_total_ff + 1'b1;
               end
               if (mark_set && (word_total_ff != WORDS_MAX)) begin
                  word_total_in = word_total_ff + 1'b1;
               end
               cursor_in = last_ff ? '0 : step_cursor;
               failed_in = last_ff ? 1'b0 : fail_new;
               if (need_mark) begin
                  state_in = ST_MARK;
               end else begin
                  rsp_in.found        = last_ff && (cmd_ff == CMD_PREFIX) && !fail_new;
                  rsp_in.status       = look_status;
                  rsp_in.words_stored = word_total_in;
                  rsp_in.nodes_used   = NODES_W'(node_total_in);
                  rsp_in.done_res     = last_ff;
                  rsp_valid_in        = 1'b1;
                  state_in            = ST_IDLE;
               end
            end
         end
         ST_MARK: begin
            if (mark_go) begin
               rsp_in.found        = mark_rdata;
               rsp_in.status       = STAT_OK;
               rsp_in.words_stored = word_total_ff;
               rsp_in.nodes_used   = NODES_W'(node_total_ff);
               rsp_in.done_res     = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         cursor_ff     <= '0;
         node_total_ff <= NTW'(1);
         word_total_ff <= '0;
         failed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         cursor_ff     <= cursor_in;
         node_total_ff <= node_total_in;
         word_total_ff <= word_total_in;
         failed_ff     <= failed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      cmd_ff     <= cmd_in;
      idx_ff     <= idx_in;
      no_char_ff <= no_char_in;
      last_ff    <= last_in;
      if (accept) begin
         slot_ff <= slot_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/trie_insert_and_lookup_unit.sv
// Top level of the trie insert and lookup unit: engine, memories, register block.
//
//   channel  ports        direction  moves
//   req      req_*        in         one character of a word, with cmd and last mark
//   rsp      rsp_*        out        one result per request: found, status, counts
//   csr      p* (APB)     in/out     char_base register at byte address 0
//
// A request is taken in the idle state, which reads the cursor node's child link
// (registered read data), and decided in the look state, which allocates and writes
// back. The last request of an exact search that did not fail goes on to the mark
// state to take the word-end mark. After reset both memories are swept to zero,
// one link entry per cycle over MAX_NODES * ALPHA_SIZE entries, with req_ready low.
// A result waits in the output register while rsp_ready is low; the engine holds.
`timescale 1ns / 1ps
`default_nettype none

module trie_insert_and_lookup_unit #(
   parameter int MAX_NODES  = trie_pkg::DEF_MAX_NODES,
   parameter int ALPHA_SIZE = trie_pkg::DEF_ALPHA_SIZE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [trie_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [trie_pkg::CODE_W-1:0]   req_char_code,
   input  wire logic                          req_no_char,
   input  wire logic                          req_last_char,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_found,
   output logic      [trie_pkg::STATUS_W-1:0] rsp_status,
   output logic      [trie_pkg::WORDS_W-1:0]  rsp_words_stored,
   output logic      [trie_pkg::NODES_W-1:0]  rsp_nodes_used,
   output logic                               rsp_done_res,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [trie_pkg::PADDR_W-1:0]  paddr,
   input  wire logic [trie_pkg::PDATA_W-1:0]  pwdata,
   output logic      [trie_pkg::PDATA_W-1:0]  prdata,
   output logic                               pready
);
   import trie_pkg::*;

   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int LINK_DEPTH = MAX_NODES * ALPHA_SIZE;
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   logic [CODE_W-1:0]  char_base;
   rsp_type            rsp;

   logic               link_we;
   logic [LINK_AW-1:0] link_waddr;
   logic [NODE_W-1:0]  link_wdata;
   logic               link_re;
   logic [LINK_AW-1:0] link_raddr;
   logic [NODE_W-1:0]  link_rdata;

   logic               mark_we;
   logic [NODE_W-1:0]  mark_waddr;
   logic               mark_wdata;
   logic               mark_re;
   logic [NODE_W-1:0]  mark_raddr;
   logic               mark_rdata;

   // Register block: holds char_base, the code that maps to alphabet index zero
   trie_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .char_base (char_base)
   );

   // Child links: one entry per (node, character); zero means no child
   trie_ram #(
      .WIDTH (NODE_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Word-end marks: one bit per node
   trie_ram #(
      .WIDTH (1),
      .DEPTH (MAX_NODES)
   ) u_mark_ram (
      .clock (clock),
      .we    (mark_we),
      .waddr (mark_waddr),
      .wdata (mark_wdata),
      .re    (mark_re),
      .raddr (mark_raddr),
      .rdata (mark_rdata)
   );

   // Walk engine: cursor, allocation, counters and the result register
   trie_ctrl #(
      .MAX_NODES  (MAX_NODES),
      .ALPHA_SIZE (ALPHA_SIZE)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .char_base     (char_base),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_char_code (req_char_code),
      .req_no_char   (req_no_char),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp           (rsp),
      .link_we       (link_we),
      .link_waddr    (link_waddr),
      .link_wdata    (link_wdata),
      .link_re       (link_re),
      .link_raddr    (link_raddr),
      .link_rdata    (link_rdata),
      .mark_we       (mark_we),
      .mark_waddr    (mark_waddr),
      .mark_wdata    (mark_wdata),
      .mark_re       (mark_re),
      .mark_raddr    (mark_raddr),
      .mark_rdata    (mark_rdata)
   );

   // Unpack the result register onto the channel ports
   assign rsp_found        = rsp.found;
   assign rsp_status       = rsp.status;
   assign rsp_words_stored = rsp.words_stored;
   assign rsp_nodes_used   = rsp.nodes_used;
   assign rsp_done_res     = rsp.done_res;

   // One request in flight: the engine is busy right after it takes one
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is still in work");

   // The clearing sweep keeps requests out right after reset
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request port open during the clearing sweep");

   // A failed step never reports a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> !rsp_found)
      else $error("found set on a result with an error status");

endmodule

`default_nettype wire
